// File: rtl/core/vrf_pkg.sv
// Shared widths and constants for the vector refraction pipeline.
// No dependencies; imported by every module of the block.
package vrf_pkg;

	localparam int unsigned VEC_W   = 16;
	localparam int unsigned OUT_W   = 20;
	localparam int unsigned DN_W    = 32;
	localparam int unsigned DOT_W   = 34;
	localparam int unsigned T42_W   = 50;
	localparam int unsigned T28_W   = 36;
	localparam int unsigned PR_W    = 53;
	localparam int unsigned P_W     = 27;
	localparam int unsigned SQ_W    = 48;
	localparam int unsigned Q_W     = 51;
	localparam int unsigned RAD_W   = 48;
	localparam int unsigned ROOT_W  = RAD_W / 2;
	localparam int unsigned AP_W    = 42;
	localparam int unsigned A_W     = 28;
	localparam int unsigned SUM_W   = 29;

	localparam logic signed [DOT_W-1:0] ONE_Q28_C = DOT_W'(64'sd268435456);
	localparam logic signed [Q_W-1:0]   ONE_Q28_Q = Q_W'(64'sd268435456);
	localparam logic signed [SUM_W-1:0] OUT_MAX   = SUM_W'(64'sd524287);
	localparam logic signed [SUM_W-1:0] OUT_MIN   = -SUM_W'(64'sd524288);

	typedef logic signed [VEC_W-1:0] vec_t;
	typedef logic signed [P_W-1:0]   perp_t;

endpackage

// File: rtl/core/vrf_isqrt.sv
// Pipelined integer square root, one result bit per stage, floor rounding.
// Carries a side payload alongside the radicand; uses vrf_pkg.
module vrf_isqrt
	import vrf_pkg::*;
#(
	parameter int unsigned RW     = 48,
	parameter int unsigned SIDE_W = 123
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic                vin,
	input  logic [RW-1:0]       rad,
	input  logic [SIDE_W-1:0]   side_in,
	output logic                vout,
	output logic [RW/2-1:0]     root,
	output logic [SIDE_W-1:0]   side_out
);

	localparam int unsigned ST  = RW / 2;
	localparam int unsigned REM = ST + 3;

	logic              v_s    [0:ST];
	logic [RW-1:0]     rad_s  [0:ST];
	logic [REM-1:0]    rem_s  [0:ST];
	logic [ST-1:0]     root_s [0:ST];
	logic [SIDE_W-1:0] side_s [0:ST];

	assign v_s[0]    = vin;
	assign rad_s[0]  = rad;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign side_s[0] = side_in;

	for (genvar k = 0; k < ST; k++) begin : g_stage
		logic [REM-1:0] rem_nx;
		logic [REM-1:0] trial;

		assign rem_nx = {rem_s[k][REM-3:0], rad_s[k][RW-1 -: 2]};
		assign trial  = REM'({root_s[k], 2'b01});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (adv) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rad_s[k+1]  <= {rad_s[k][RW-3:0], 2'b00};
				side_s[k+1] <= side_s[k];
				if (rem_nx >= trial) begin
					rem_s[k+1]  <= rem_nx - trial;
					root_s[k+1] <= {root_s[k][ST-2:0], 1'b1};
				end else begin
					rem_s[k+1]  <= rem_nx;
					root_s[k+1] <= {root_s[k][ST-2:0], 1'b0};
				end
			end
		end
	end

	assign vout     = v_s[ST];
	assign root     = root_s[ST];
	assign side_out = side_s[ST];

endmodule

// File: rtl/core/vector_refract.sv
// Refracts an incident direction at a surface with normal n and index ratio r
// (Snell's law); one beat in per cycle while the output is not stalled. The
// pipeline holds the 24-stage square root, one result bit per stage, with
// ten arithmetic stages around it. The whole pipeline stalls together when
// the output register is full and not taken; no total internal reflection
// flag is given. Uses vrf_pkg and vrf_isqrt.
module vector_refract
	import vrf_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    hit_valid,
	output logic                    hit_ready,
	input  logic signed [VEC_W-1:0] dir_x,
	input  logic signed [VEC_W-1:0] dir_y,
	input  logic signed [VEC_W-1:0] dir_z,
	input  logic signed [VEC_W-1:0] norm_x,
	input  logic signed [VEC_W-1:0] norm_y,
	input  logic signed [VEC_W-1:0] norm_z,
	input  logic [VEC_W-1:0]        index_ratio,
	output logic                    res_valid,
	input  logic                    res_ready,
	output logic signed [OUT_W-1:0] out_x,
	output logic signed [OUT_W-1:0] out_y,
	output logic signed [OUT_W-1:0] out_z
);

	localparam int unsigned SIDE_W = 3 * P_W + 3 * VEC_W;

	logic adv;
	vec_t d_in [3];
	vec_t n_in [3];

	logic                    v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	logic signed [DN_W-1:0]  dn_s1 [3];
	vec_t                    d_s1 [3], n_s1 [3], d_s2 [3], n_s2 [3];
	vec_t                    n_s3 [3], n_s4 [3], n_s5 [3], n_s6 [3], n_s7 [3], n_s8 [3];
	logic [VEC_W-1:0]        r_s1, r_s2, r_s3, r_s4;
	logic signed [DOT_W-1:0] c_s2;
	logic signed [T42_W-1:0] t42_s3 [3];
	logic signed [T28_W-1:0] t28_s4 [3];
	logic signed [PR_W-1:0]  pr_s5 [3];
	perp_t                   p_s6 [3], p_s7 [3], p_s8 [3], p_s9 [3];
	logic [SQ_W-1:0]         sq_s7 [3];
	logic [RAD_W-1:0]        rad_s8;
	logic signed [AP_W-1:0]  ap_s9 [3];

	logic                    sq_v;
	logic [ROOT_W-1:0]       sq_root;
	logic [SIDE_W-1:0]       side_in, side_out;
	perp_t                   p_sq [3];
	vec_t                    n_sq [3];

	logic signed [DOT_W-1:0] dot_sum, neg_dot;
	logic signed [Q_W-1:0]   q_sum, diff;

	assign adv       = !res_valid || res_ready;
	assign hit_ready = adv;

	assign d_in[0] = dir_x;
	assign d_in[1] = dir_y;
	assign d_in[2] = dir_z;
	assign n_in[0] = norm_x;
	assign n_in[1] = norm_y;
	assign n_in[2] = norm_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
			res_valid <= 1'b0;
		end else if (adv) begin
			v_s1 <= hit_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= sq_v;
			res_valid <= v_s9;
		end
	end

	assign dot_sum = DOT_W'(dn_s1[0]) + DOT_W'(dn_s1[1]) + DOT_W'(dn_s1[2]);
	assign neg_dot = -dot_sum;
	assign q_sum   = Q_W'({1'b0, sq_s7[0]}) + Q_W'({1'b0, sq_s7[1]})
		+ Q_W'({1'b0, sq_s7[2]});
	assign diff    = ONE_Q28_Q - q_sum;

	always_ff @(posedge clk) begin
		if (adv) begin
			r_s1 <= index_ratio;
			r_s2 <= r_s1;
			r_s3 <= r_s2;
			r_s4 <= r_s3;
			c_s2 <= (neg_dot > ONE_Q28_C) ? ONE_Q28_C : neg_dot;
			rad_s8 <= diff[Q_W-1] ? RAD_W'(-diff) : RAD_W'(diff);
			for (int i = 0; i < 3; i++) begin
				dn_s1[i]  <= d_in[i] * n_in[i];
				d_s1[i]   <= d_in[i];
				n_s1[i]   <= n_in[i];
				d_s2[i]   <= d_s1[i];
				n_s2[i]   <= n_s1[i];
				n_s3[i]   <= n_s2[i];
				n_s4[i]   <= n_s3[i];
				n_s5[i]   <= n_s4[i];
				n_s6[i]   <= n_s5[i];
				n_s7[i]   <= n_s6[i];
				n_s8[i]   <= n_s7[i];
				t42_s3[i] <= T42_W'({{(T42_W-VEC_W-28){d_s2[i][VEC_W-1]}}, d_s2[i], 28'd0})
					+ T42_W'(c_s2) * T42_W'(n_s2[i]);
				t28_s4[i] <= T28_W'((t42_s3[i] + T42_W'(64'sd8192)) >>> 14);
				pr_s5[i]  <= t28_s4[i] * $signed({1'b0, r_s4});
				p_s6[i]   <= P_W'((pr_s5[i] + PR_W'(64'sd33554432)) >>> 26);
				p_s7[i]   <= p_s6[i];
				sq_s7[i]  <= SQ_W'(p_s6[i]) * SQ_W'(p_s6[i]);
				p_s8[i]   <= p_s7[i];
				p_s9[i]   <= p_sq[i];
				ap_s9[i]  <= -(AP_W'($signed({1'b0, sq_root})) * AP_W'(n_sq[i]));
			end
		end
	end

	assign side_in = {p_s8[0], p_s8[1], p_s8[2], n_s8[0], n_s8[1], n_s8[2]};
	assign {p_sq[0], p_sq[1], p_sq[2], n_sq[0], n_sq[1], n_sq[2]} = side_out;

	vrf_isqrt #(
		.RW     (RAD_W),
		.SIDE_W (SIDE_W)
	) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.vin      (v_s8),
		.rad      (rad_s8),
		.side_in  (side_in),
		.vout     (sq_v),
		.root     (sq_root),
		.side_out (side_out)
	);

	logic signed [A_W-1:0]   a_c [3];
	logic signed [SUM_W-1:0] o_c [3];
	logic signed [OUT_W-1:0] sat_c [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			a_c[i] = A_W'((ap_s9[i] + AP_W'(64'sd8192)) >>> 14);
			o_c[i] = SUM_W'(p_s9[i]) + SUM_W'(a_c[i]);
			if (o_c[i] > OUT_MAX) begin
				sat_c[i] = OUT_W'(OUT_MAX);
			end else if (o_c[i] < OUT_MIN) begin
				sat_c[i] = OUT_W'(OUT_MIN);
			end else begin
				sat_c[i] = OUT_W'(o_c[i]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_x <= sat_c[0];
			out_y <= sat_c[1];
			out_z <= sat_c[2];
		end
	end

endmodule

// File: rtl/core/vrf_checker.sv
// Port-level checks for vector_refract, attached by the bind at the end.
// Uses vrf_pkg for the port widths.
module vrf_checker
	import vrf_pkg::*;
(
	input logic                    clk,
	input logic                    arst_n,
	input logic                    hit_valid,
	input logic                    hit_ready,
	input logic signed [VEC_W-1:0] dir_x,
	input logic signed [VEC_W-1:0] dir_y,
	input logic signed [VEC_W-1:0] dir_z,
	input logic signed [VEC_W-1:0] norm_x,
	input logic signed [VEC_W-1:0] norm_y,
	input logic signed [VEC_W-1:0] norm_z,
	input logic [VEC_W-1:0]        index_ratio,
	input logic                    res_valid,
	input logic                    res_ready,
	input logic signed [OUT_W-1:0] out_x,
	input logic signed [OUT_W-1:0] out_y,
	input logic signed [OUT_W-1:0] out_z
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(out_x) && $stable(out_y)
		&& $stable(out_z))
		else $error("result beat changed while stalled");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> hit_ready)
		else $error("input stalled with empty output");

	a_take_ready: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready |-> hit_ready)
		else $error("input stalled while result is taken");

	a_stall_block: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |-> !hit_ready)
		else $error("input accepted during output stall");

endmodule

bind vector_refract vrf_checker u_vrf_checker (.*);
